### design/mbps_pkg.sv
// Shared constants and types for the match bit position scanner.
package mbps_pkg;

   localparam int WORD_BITS_DEFAULT   = 64;
   localparam int MAX_STREAMS_DEFAULT = 16;

   localparam int DATA_W      = 64;
   localparam int SIDX_W      = 4;
   localparam int CNT_W       = 5;
   localparam int BIT_IDX_W   = 6;
   localparam int RSP_TDATA_W = 72;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0] STREAM_COUNT_RESET = CNT_W'(1);

   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic [DATA_W-1:0] base;
      logic [SIDX_W-1:0] sidx;
   } qentry_type;

endpackage

### design/mbps_front.sv
// Front end: accepts match words, tags them with stream and column base, queues nonzero words.
module mbps_front
   import mbps_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEFAULT,
   parameter int MAX_STREAMS = MAX_STREAMS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  stream_count,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              q_full,
   output logic              q_push,
   output qentry_type        q_push_data
);

   localparam int STREAM_CAP = (MAX_STREAMS < 16) ? MAX_STREAMS : 16;
   localparam logic [DATA_W-1:0] WORD_MASK =
      (WORD_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << WORD_BITS) - DATA_W'(1));

   logic [SIDX_W-1:0] stream_counter_ff, stream_counter_in;
   logic [DATA_W-1:0] column_base_ff, column_base_in;
   logic [CNT_W-1:0]  eff_streams;
   logic [CNT_W-1:0]  next_count;
   logic              req_fire;
   logic              wrap;
   logic [DATA_W-1:0] masked_word;

   assign req_tready  = !q_full;
   assign req_fire    = req_tvalid && req_tready;
   assign masked_word = req_tdata & WORD_MASK;

   always_comb begin
      if (stream_count == '0) begin
         eff_streams = CNT_W'(1);
      end else if (stream_count > CNT_W'(STREAM_CAP)) begin
         eff_streams = CNT_W'(STREAM_CAP);
      end else begin
         eff_streams = stream_count;
      end
   end

   assign next_count = {1'b0, stream_counter_ff} + CNT_W'(1);
   assign wrap       = next_count >= eff_streams;

   always_comb begin
      stream_counter_in = stream_counter_ff;
      column_base_in    = column_base_ff;
      if (req_fire) begin
         if (wrap) begin
            stream_counter_in = '0;
            column_base_in    = column_base_ff + DATA_W'(WORD_BITS);
         end else begin
            stream_counter_in = next_count[SIDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_counter_ff <= '0;
         column_base_ff    <= '0;
      end else begin
         stream_counter_ff <= stream_counter_in;
         column_base_ff    <= column_base_in;
      end
   end

   // empty words only advance the stream and column
   assign q_push           = req_fire && (masked_word != '0);
   assign q_push_data.word = masked_word;
   assign q_push_data.base = column_base_ff;
   assign q_push_data.sidx = stream_counter_ff;

   a_base_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && wrap) |=> column_base_ff == $past(column_base_ff) + DATA_W'(WORD_BITS))
      else $error("column base did not advance at end of column");

endmodule

### design/mbps_fifo.sv
// Short word queue between front and back end.
module mbps_fifo
   import mbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       q_valid,
   output qentry_type q_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   qentry_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;

   assign full    = count_ff == CNT_QW'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");

endmodule

### design/mbps_back.sv
// Back end: scans queued words lowest set bit first and emits one position per cycle while the output is not stalled.
module mbps_back
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  qentry_type             q_data,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   // scan register
   logic              busy_ff, busy_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] cur_base_ff;
   logic [SIDX_W-1:0] cur_sidx_ff;

   // bit index stage
   logic                 a_valid_ff, a_valid_in;
   logic [BIT_IDX_W-1:0] a_idx_ff;
   logic [DATA_W-1:0]    a_base_ff;
   logic [SIDX_W-1:0]    a_sidx_ff;
   logic                 a_last_ff;

   // output register
   logic              b_valid_ff, b_valid_in;
   logic [DATA_W-1:0] b_pos_ff;
   logic [SIDX_W-1:0] b_sidx_ff;
   logic              b_last_ff;

   logic                 b_free, a_free;
   logic                 scan_fire, scan_last;
   logic [DATA_W-1:0]    dec_word, low_bit, next_word;
   logic [BIT_IDX_W-1:0] low_idx;

   assign b_free    = !b_valid_ff || rsp_tready;
   assign a_free    = !a_valid_ff || b_free;
   assign scan_fire = busy_ff && a_free;

   assign dec_word  = cur_ff - DATA_W'(1);
   assign low_bit   = cur_ff & ~dec_word;
   assign next_word = cur_ff & dec_word;
   assign scan_last = next_word == '0;

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < DATA_W; i++) begin
         low_idx = low_idx | (low_bit[i] ? BIT_IDX_W'(i) : '0);
      end
   end

   assign q_pop = q_valid && (!busy_ff || (scan_fire && scan_last));

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         cur_in  = q_data.word;
      end else if (scan_fire) begin
         busy_in = !scan_last;
         cur_in  = next_word;
      end
   end

   assign a_valid_in = a_free ? scan_fire : a_valid_ff;
   assign b_valid_in = b_free ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (q_pop) begin
         cur_base_ff <= q_data.base;
         cur_sidx_ff <= q_data.sidx;
      end
      if (scan_fire) begin
         a_idx_ff  <= low_idx;
         a_base_ff <= cur_base_ff;
         a_sidx_ff <= cur_sidx_ff;
         a_last_ff <= scan_last;
      end
      if (a_valid_ff && b_free) begin
         b_pos_ff  <= a_base_ff + DATA_W'(a_idx_ff);
         b_sidx_ff <= a_sidx_ff;
         b_last_ff <= a_last_ff;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - DATA_W - SIDX_W){1'b0}}, b_sidx_ff, b_pos_ff};
   assign rsp_tlast  = b_last_ff;

   a_busy_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cur_ff != '0)
      else $error("scanner busy on empty word");

   a_one_bit_cleared: assert property (@(posedge clock) disable iff (reset)
      (scan_fire && !q_pop) |=> $countones(cur_ff) == $countones($past(cur_ff)) - 1)
      else $error("scan step did not clear exactly one bit");

endmodule

### design/match_bit_position_scanner.sv
// Match bit position scanner top level: config register, front end, queue, back end.
// The first position of a word passes through the word queue, scan register, bit index stage and output register.
// Throughput: one position per cycle from the back-end scan loop while the output is not stalled; a word
// holds the scanner until each of its set bits is scanned, and empty words are absorbed by the front end.
// Input stalls when the two-entry word queue is full.
// Synchronous active-high reset: stream count 1, column base and stream counter zero.
module match_bit_position_scanner
   import mbps_pkg::*;
#(
   parameter int WORD_BITS   = WORD_BITS_DEFAULT,
   parameter int MAX_STREAMS = MAX_STREAMS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data,  // stream_count
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,    // [63:0] match_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,    // [63:0] match_position, [67:64] stream_index
   output logic                   rsp_tlast     // last_of_word
);

   logic [CNT_W-1:0] stream_count_ff;
   logic             q_full, q_push, q_pop, q_valid;
   qentry_type       q_push_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_count_ff <= STREAM_COUNT_RESET;
      end else if (csr_wr_en) begin
         stream_count_ff <= csr_wr_data;
      end
   end

   mbps_front #(
      .WORD_BITS   (WORD_BITS),
      .MAX_STREAMS (MAX_STREAMS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .stream_count (stream_count_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_data  (q_push_data)
   );

   mbps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   mbps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/tb_top.sv
// Testbench for match_bit_position_scanner: random and directed match words, checked.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mbps_pkg::*;

   localparam int IDLE_PCT     = 35;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 24;

   class match_scoreboard;
      typedef struct {
         logic [DATA_W-1:0] position;
         logic [SIDX_W-1:0] stream;
         logic              last;
      } hit_type;

      hit_type           hit_q[$];
      int unsigned       errors;
      logic [CNT_W-1:0]  stream_count;
      logic [DATA_W-1:0] column_base;
      logic [SIDX_W-1:0] stream_ctr;

      function new();
         errors       = 0;
         stream_count = STREAM_COUNT_RESET;
         column_base  = '0;
         stream_ctr   = '0;
      endfunction

      function void set_stream_count(logic [CNT_W-1:0] v);
         stream_count = v;
      endfunction

      function int pending();
         return hit_q.size();
      endfunction

      // every set bit, lowest first; then advance stream and column
      function void note_word(logic [DATA_W-1:0] w);
         int      active;
         int      cap;
         int      found;
         hit_type h;
         cap    = (MAX_STREAMS_DEFAULT < 16) ? MAX_STREAMS_DEFAULT : 16;
         active = (stream_count == 0) ? 1 : int'(stream_count);
         if (active > cap) begin
            active = cap;
         end
         found = 0;
         for (int i = 0; i < WORD_BITS_DEFAULT && i < DATA_W; i++) begin
            if (w[i]) begin
               h.position = column_base + DATA_W'(i);
               h.stream   = stream_ctr;
               h.last     = 1'b0;
               hit_q      = {hit_q, h};
               found++;
            end
         end
         if (found > 0) begin
            hit_q[hit_q.size()-1].last = 1'b1;
         end
         if (int'(stream_ctr) + 1 >= active) begin
            stream_ctr  = '0;
            column_base = column_base + DATA_W'(WORD_BITS_DEFAULT);
         end else begin
            stream_ctr = stream_ctr + 1'b1;
         end
      endfunction

      function void take_position(logic [DATA_W-1:0] position, logic [SIDX_W-1:0] stream,
                                  logic last);
         hit_type h;
         if (hit_q.size() == 0) begin
            $error("unexpected position %h stream %0d last %b", position, stream, last);
            errors++;
         end else begin
            h = hit_q.pop_front();
            if (position !== h.position) begin
               $error("match_position expected %h actual %h", h.position, position);
               errors++;
            end
            if (stream !== h.stream) begin
               $error("stream_index expected %0d actual %0d", h.stream, stream);
               errors++;
            end
            if (last !== h.last) begin
               $error("last_of_word expected %b actual %b", h.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CNT_W-1:0]       csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   match_scoreboard sb = new();
   bit              quiet = 1'b0;
   bit              hold_req = 1'b0;

   match_bit_position_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always #2 clock = ~clock;

   // receiver: random backpressure, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.take_position(rsp_tdata[DATA_W-1:0], rsp_tdata[DATA_W+SIDX_W-1:DATA_W], rsp_tlast);
      end
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_word(input logic [DATA_W-1:0] w);
      int gaps;
      gaps = 0;
      if (!quiet) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gaps++;
      end
      if (gaps > 0) begin
         req_tvalid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      sb.note_word(w);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CNT_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_stream_count(v);
   endtask

   function automatic logic [DATA_W-1:0] rand_word();
      logic [DATA_W-1:0] w;
      int                kind;
      kind = $urandom_range(0, 99);
      w    = '0;
      if (kind < 10) begin
         w = '0;
      end else if (kind < 60) begin
         repeat ($urandom_range(1, 3)) w[$urandom_range(0, DATA_W-1)] = 1'b1;
      end else if (kind < 80) begin
         w = {$urandom, $urandom};
      end else if (kind < 85) begin
         w = '1;
      end else begin
         w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      end
      return w;
   endfunction

   initial begin
      logic [CNT_W-1:0] cnt;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, empty words, count changes
      write_csr(5'd3);
      send_word(64'h0);
      send_word('1);
      send_word(64'h1);
      send_word(64'h8000_0000_0000_0000);
      send_word(64'hAAAA_AAAA_AAAA_AAAA);
      send_word(64'h5555_5555_5555_5555);
      write_csr(5'd5);
      send_word(64'h0000_0001_0000_0000);
      send_word(64'h0000_0000_0000_00F0);
      send_word(64'h0);
      // count lowered while stream counter sits at 3
      write_csr(5'd2);
      send_word(64'h8000_0000_0000_0001);
      send_word(64'h10);
      send_word(64'h0);
      write_csr(5'd0);
      send_word(64'h3);
      send_word(64'hC000_0000_0000_0000);
      write_csr(5'd31);
      send_word(64'h1_0000);
      send_word('1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cnt = 5'd16;
            1: cnt = 5'd1;
            2: cnt = 5'd17;
            7: cnt = CNT_W'($urandom_range(0, 31));
            default: cnt = CNT_W'($urandom_range(1, 16));
         endcase
         write_csr(cnt);
         if (p == 3) begin
            hold_req = 1'b1;
         end
         if (p == 5) begin
            quiet = 1'b1;
         end
         repeat (PHASE_WORDS) send_word(rand_word());
         quiet = 1'b0;
      end

      drain();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
